// File: rtl/core/rpss_pkg.sv
// shared types and constants for the rna path sequence sampler
package rpss_pkg;

  localparam logic [2:0] BASE_A = 3'd0;
  localparam logic [2:0] BASE_C = 3'd1;
  localparam logic [2:0] BASE_G = 3'd2;
  localparam logic [2:0] BASE_U = 3'd3;
  localparam logic [2:0] BASE_X = 3'd4;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_DRAW  = 1'b1;

  localparam int unsigned CountW = 64;

  // width of the random fraction, fixed by the input transfer layout
  localparam int unsigned RandomBits = 16;

  // one-edge pairing: AU, UA, GC, CG, GU, UG
  function automatic logic pairs(input logic [1:0] a, input logic [1:0] b);
    logic [3:0] row;
    begin
      row = 4'b0000;
      case (a)
        2'd0: row = 4'b1000;
        2'd1: row = 4'b0100;
        2'd2: row = 4'b1010;
        default: row = 4'b0101;
      endcase
      pairs = row[b];
    end
  endfunction

  typedef struct packed {
    logic [1:0] base;
    logic       has_base;
    logic [62:0] total_count;
    logic       last_of_path;
    logic       conflict;
    logic       out_of_range;
  } result_t;

endpackage

// File: rtl/core/rna_path_sequence_sampler.sv
// top level of the rna path sequence sampler
// Uniform sampler of RNA sequences along a path whose neighbors pair (AU, GC,
// GU). After reset a fill sequencer builds the table of path counts by length
// (levels 0 and 1 written directly, then matrix powers, each entry a sum of
// four reads of the level below); s_axis_tready stays low until it is done.
// All table reads go through the single read port. A start transfer sums 1, 4
// or 16 table words, one read per cycle. A draw transfer sums the normalizer
// (1 to 16 words) and then, for each allowed next base in order, forms a 64x16
// product in two 32x16 halves and the running candidate count (1 or 4 words);
// the worst draw is one with both the current and the far base unknown. A
// start or draw that is out of range answers from ST_OOR without reading the
// table. The block takes the next transfer in the cycle after a result is
// formed, even while that result still waits in the output register; the next
// result is held back until the waiting one has left. The scaled compare
// r*n < s*2^RandomBits is exact, with the 64x16 product split into two halves
// in ST_MUL1 and ST_MUL2.
module rna_path_sequence_sampler #(
  parameter int unsigned MAX_LENGTH  = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // first_base[3], last_base[3], path_length[6], random_fraction[16], pad
  input  logic [31:0] s_axis_tdata,
  // action
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // base[2], total_count[63], conflict, out_of_range, pad
  output logic [71:0] m_axis_tdata,
  // has_base
  output logic        m_axis_tuser,
  // last_of_path
  output logic        m_axis_tlast
);
  import rpss_pkg::*;

  localparam int unsigned Levels = MAX_LENGTH + 2;
  localparam int unsigned Depth  = Levels * 16;
  localparam int unsigned AW     = $clog2(Depth);
  localparam int unsigned LW     = $clog2(Levels + 1);

  // sequencer states
  localparam logic [3:0] ST_INIT  = 4'd0;  // fill: issue read of a*k
  localparam logic [3:0] ST_FMUL  = 4'd1;  // fill: wait / accumulate
  localparam logic [3:0] ST_IDLE  = 4'd2;
  localparam logic [3:0] ST_SUM   = 4'd3;  // sum table words
  localparam logic [3:0] ST_SDONE = 4'd4;  // start result
  localparam logic [3:0] ST_NORM  = 4'd5;  // draw: normalizer summed
  localparam logic [3:0] ST_MUL1  = 4'd6;
  localparam logic [3:0] ST_MUL2  = 4'd7;
  localparam logic [3:0] ST_CAND  = 4'd8;  // draw: set up candidate sum
  localparam logic [3:0] ST_CMP   = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;
  localparam logic [3:0] ST_OOR   = 4'd11; // out of range result

  logic [3:0] st_q, st_d;

  // table ram
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;

  rpss_ram #(.Width(CountW), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // path state
  logic [2:0]    cur_q, cur_d, end_q, end_d;
  logic [LW-1:0] rem_q, rem_d;
  logic          act_q, act_d;

  // fill walker: level, i, j, k
  logic [LW-1:0] fl_q, fl_d;
  logic [3:0]    fij_q, fij_d;
  logic [1:0]    fk_q, fk_d;
  logic [63:0]   acc_q, acc_d;

  // sum walker over (a,b) in 0..15 with masks
  logic [LW-1:0] sl_q, sl_d;
  logic [3:0]    aset_q, aset_d, bset_q, bset_d;
  logic [3:0]    ab_q, ab_d;        // next address pair to read
  logic          pend_q, pend_d;    // a read is in flight
  logic [63:0]   n_q, n_d, s_q, s_d;
  logic [1:0]    cand_q, cand_d;
  logic [15:0]   r_q, r_d;
  logic [95:0]   p_q, p_d;
  logic          cmd_start_q, cmd_start_d;
  logic [2:0]    fb_q, fb_d;
  logic [5:0]    len_q, len_d;

  result_t res_q, res_d;
  logic    ov_q, ov_d;

  // input fields
  logic          in_act;
  logic [2:0]    in_fb, in_lb;
  logic [5:0]    in_len;
  logic [15:0]   in_r;
  assign in_act = s_axis_tuser;
  assign in_fb  = (s_axis_tdata[2:0] > BASE_X) ? BASE_X : s_axis_tdata[2:0];
  assign in_lb  = (s_axis_tdata[5:3] > BASE_X) ? BASE_X : s_axis_tdata[5:3];
  assign in_len = s_axis_tdata[11:6];
  assign in_r   = s_axis_tdata[27:12];

  // take a new transfer whenever idle; results wait for a free output slot
  logic out_free;
  assign out_free      = !ov_q || m_axis_tready;
  assign s_axis_tready = (st_q == ST_IDLE);
  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // base selection mask for a code
  function automatic logic [3:0] bmask(input logic [2:0] b);
    bmask = (b == BASE_X) ? 4'hF : (4'b0001 << b[1:0]);
  endfunction

  // next set bit at or after pos in the 16-bit (a,b) product mask
  logic [15:0] abmask;
  always_comb begin
    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        abmask[a*4+b] = aset_q[a] & bset_q[b];
      end
    end
  end
  logic [15:0] rest;
  logic [3:0]  nxt;
  logic        has_nxt;
  always_comb begin
    rest    = abmask & (16'hFFFF << ab_q);
    nxt     = '0;
    has_nxt = 1'b0;
    for (int i = 15; i >= 0; i--) begin
      if (rest[i]) begin
        nxt     = 4'(i);
        has_nxt = 1'b1;
      end
    end
  end

  logic [AW-1:0] sum_addr;
  assign sum_addr = AW'(sl_q) * AW'(16) + AW'(nxt);

  // scaled compare pieces
  logic [63:0] s_lo, s_hi;
  assign s_lo = s_q << RandomBits;
  assign s_hi = s_q >> (64 - RandomBits);
  logic [127:0] prod;
  assign prod = {32'd0, p_q};
  logic [127:0] scaled;
  assign scaled = {s_hi, s_lo};

  always_comb begin
    st_d = st_q; cur_d = cur_q; end_d = end_q; rem_d = rem_q; act_d = act_q;
    fl_d = fl_q; fij_d = fij_q; fk_d = fk_q; acc_d = acc_q;
    sl_d = sl_q; aset_d = aset_q; bset_d = bset_q; ab_d = ab_q; pend_d = 1'b0;
    n_d = n_q; s_d = s_q; cand_d = cand_q; r_d = r_q; p_d = p_q;
    cmd_start_d = cmd_start_q; fb_d = fb_q; len_d = len_q;
    res_d = res_q; ov_d = ov_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    if (ov_q && m_axis_tready) ov_d = 1'b0;

    unique case (st_q)
      ST_INIT: begin
        // fill levels 0 and 1 directly, higher levels as matrix products
        if (fl_q < LW'(2)) begin
          we    = 1'b1;
          waddr = AW'(fl_q) * AW'(16) + AW'(fij_q);
          wdata = (fl_q == '0) ? 64'(fij_q[3:2] == fij_q[1:0])
                               : 64'(pairs(fij_q[3:2], fij_q[1:0]));
          fij_d = fij_q + 4'd1;
          if (fij_q == 4'hF) fl_d = fl_q + LW'(1);
        end else begin
          raddr = AW'(fl_q - LW'(1)) * AW'(16) + AW'({fij_q[3:2], fk_q});
          acc_d = '0;
          st_d  = ST_FMUL;
        end
      end
      ST_FMUL: begin
        // data of read for current k arrives; issue the next
        if (pairs(fk_q, fij_q[1:0])) acc_d = acc_q + rdata;
        if (fk_q == 2'd3) begin
          we    = 1'b1;
          waddr = AW'(fl_q) * AW'(16) + AW'(fij_q);
          wdata = acc_d;
          fk_d  = '0;
          fij_d = fij_q + 4'd1;
          if (fij_q == 4'hF) begin
            fl_d = fl_q + LW'(1);
            st_d = (fl_q == LW'(Levels - 1)) ? ST_IDLE : ST_INIT;
          end else begin
            st_d = ST_INIT;
          end
        end else begin
          fk_d  = fk_q + 2'd1;
          raddr = AW'(fl_q - LW'(1)) * AW'(16) + AW'({fij_q[3:2], fk_d});
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_act == ACT_START) begin
            act_d = 1'b0;
            if (32'(in_len) > MAX_LENGTH) begin
              st_d = ST_OOR;
            end else begin
              cmd_start_d = 1'b1;
              fb_d = in_fb; len_d = in_len; end_d = in_lb;
              sl_d = LW'(in_len);
              aset_d = bmask(in_fb); bset_d = bmask(in_lb);
              ab_d = '0; s_d = '0;
              st_d = ST_SUM;
            end
          end else if (!act_q || rem_q == '0) begin
            st_d = ST_OOR;
          end else begin
            cmd_start_d = 1'b0;
            r_d = in_r;
            // normalizer
            if (cur_q == BASE_X) begin
              sl_d = rem_q - LW'(1); aset_d = 4'hF;
            end else begin
              sl_d = rem_q; aset_d = bmask(cur_q);
            end
            bset_d = bmask(end_q);
            ab_d = '0; s_d = '0; cand_d = '0;
            st_d = ST_SUM;
          end
        end
      end
      ST_OOR: begin
        if (out_free) begin
          res_d = '0;
          res_d.out_of_range = 1'b1;
          ov_d = 1'b1;
          st_d = ST_IDLE;
        end
      end
      ST_SUM: begin
        // accumulate read data, issue next read
        if (pend_q) s_d = s_q + rdata;
        if (has_nxt) begin
          raddr  = sum_addr;
          pend_d = 1'b1;
          ab_d   = nxt + 4'd1;
          if (nxt == 4'hF) aset_d = 4'h0;  // last element taken: empty the set
        end else if (!pend_q) begin
          st_d = cmd_start_q ? ST_SDONE : ST_NORM;
        end
      end
      ST_SDONE: begin
        if (out_free) begin
          res_d = '0;
          res_d.total_count = s_q[62:0];
          if (s_q == '0) begin
            res_d.conflict = 1'b1;
          end else begin
            cur_d = fb_q;
            if (fb_q != BASE_X) begin
              res_d.base = fb_q[1:0];
              res_d.has_base = 1'b1;
              rem_d = LW'(len_q);
              res_d.last_of_path = (len_q == '0);
              act_d = (len_q != '0);
            end else begin
              rem_d = LW'(len_q) + LW'(1);
              act_d = 1'b1;
            end
          end
          ov_d = 1'b1;
          st_d = ST_IDLE;
        end
      end
      ST_NORM: begin
        n_d = s_q;
        s_d = '0;
        st_d = ST_CAND;
      end
      ST_CAND: begin
        // set up sum for candidate cand_q at level rem-1, skipping non-pairs
        if (cur_q != BASE_X && !pairs(cur_q[1:0], cand_q)) begin
          if (cand_q == 2'd3) begin
            if (out_free) begin
              res_d = '0; res_d.conflict = 1'b1;
              act_d = 1'b0; ov_d = 1'b1; st_d = ST_IDLE;
            end
          end else begin
            cand_d = cand_q + 2'd1;
          end
        end else begin
          sl_d = rem_q - LW'(1);
          aset_d = 4'b0001 << cand_q; bset_d = bmask(end_q);
          ab_d = '0;
          st_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        p_d = {32'd0, 64'(n_q[31:0]) * 64'(r_q)};
        st_d = ST_MUL2;
      end
      ST_MUL2: begin
        p_d = p_q + ({32'd0, 64'(n_q[63:32]) * 64'(r_q)} << 32);
        st_d = ST_OUT;
      end
      ST_OUT: begin
        // add the candidate words to the running sum
        if (pend_q) s_d = s_q + rdata;
        if (has_nxt) begin
          raddr = sum_addr; pend_d = 1'b1; ab_d = nxt + 4'd1;
          if (nxt == 4'hF) aset_d = 4'h0;
        end else if (!pend_q) begin
          st_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (prod < scaled) begin
          if (out_free) begin
            res_d = '0;
            res_d.base = cand_q; res_d.has_base = 1'b1;
            cur_d = {1'b0, cand_q}; rem_d = rem_q - LW'(1);
            if (rem_q == LW'(1)) begin
              res_d.last_of_path = 1'b1; act_d = 1'b0;
            end
            ov_d = 1'b1; st_d = ST_IDLE;
          end
        end else if (cand_q == 2'd3) begin
          if (out_free) begin
            res_d = '0; res_d.conflict = 1'b1;
            act_d = 1'b0; ov_d = 1'b1; st_d = ST_IDLE;
          end
        end else begin
          cand_d = cand_q + 2'd1;
          st_d = ST_CAND;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_INIT; cur_q <= BASE_X; end_q <= BASE_X; rem_q <= '0;
      act_q <= 1'b0; fl_q <= '0; fij_q <= '0; fk_q <= '0;
      pend_q <= 1'b0; ov_q <= 1'b0; cmd_start_q <= 1'b0;
    end else begin
      st_q <= st_d; cur_q <= cur_d; end_q <= end_d; rem_q <= rem_d;
      act_q <= act_d; fl_q <= fl_d; fij_q <= fij_d; fk_q <= fk_d;
      pend_q <= pend_d; ov_q <= ov_d; cmd_start_q <= cmd_start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; sl_q <= sl_d; aset_q <= aset_d; bset_q <= bset_d; ab_q <= ab_d;
    n_q <= n_d; s_q <= s_d; cand_q <= cand_d; r_q <= r_d; p_q <= p_d;
    fb_q <= fb_d; len_q <= len_d; res_q <= res_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = res_q.last_of_path;
  assign m_axis_tuser  = res_q.has_base;
  assign m_axis_tdata  = {5'd0, res_q.out_of_range, res_q.conflict,
                          res_q.total_count, res_q.base};

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> st_q == ST_IDLE) else $error("ready outside idle");
  a_base_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res_q.has_base |-> res_q.base == 2'd0)
    else $error("base without flag");
  a_last_has: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> res_q.has_base) else $error("last w/o base");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(res_q))
    else $error("result changed while waiting");

endmodule

// File: rtl/core/rpss_ram.sv
// generic single-port-write, single-port-read ram with registered read
module rpss_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1040
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
